// ===== rtl/weno3_pkg.sv =====
// Shared types, constants and helper functions for the WENO3 face reconstruction pipeline.
`default_nettype none

package weno3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int AVG_W      = 32;
    localparam int WIDTH_W    = 31;
    localparam int EPS_W      = 32;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;

    localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (DATA_WIDTH - 1)) - 40'sd1;
    localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

    // Restoring divider: 32 quotient bits, DIV_STEP bits per stage
    localparam int QUOT_W     = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = QUOT_W / DIV_STEP;

    typedef struct packed {
        logic                fault;
        logic [WIDTH_W-1:0]  h1;
        logic [WIDTH_W-1:0]  h3;
        logic [31:0]         s12;
        logic [31:0]         s23;
        logic signed [31:0]  u2;
        logic                neg1;
        logic                neg3;
        logic signed [33:0]  e1;
        logic signed [33:0]  e2;
        logic                dneg;
        logic [32:0]         dmag;
        logic signed [34:0]  pbl;
        logic signed [34:0]  pbr;
        logic                wl_hi;
        logic                wr_hi;
    } side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] dvs;
        logic [31:0] quo;
    } div_lane_t;

    function automatic logic [6:0] bit_len64(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    // Shift count that brings a value of the given bit length below 2^lim
    function automatic logic [5:0] shift_cnt(input logic [6:0] len, input logic [6:0] lim);
        logic [6:0] d;
        d = len - lim;
        return (len > lim) ? d[5:0] : 6'd0;
    endfunction

    function automatic div_lane_t div_steps(input div_lane_t x);
        div_lane_t   y;
        logic [32:0] r2;
        y = x;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            r2    = {y.rem, y.low[31]};
            y.low = {y.low[30:0], 1'b0};
            if (r2 >= {1'b0, y.dvs})
            begin
                y.rem = 32'(r2 - {1'b0, y.dvs});
                y.quo = {y.quo[30:0], 1'b1};
            end
            else
            begin
                y.rem = r2[31:0];
                y.quo = {y.quo[30:0], 1'b0};
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/weno3_front.sv =====
// Input stage: width sums, average differences and the skew products feeding the divider.
`default_nettype none

module weno3_front
    import weno3_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [WIDTH_W-1:0]     h1,
    input  wire logic [WIDTH_W-1:0]     h2,
    input  wire logic [WIDTH_W-1:0]     h3,
    input  wire logic signed [AVG_W-1:0] u1,
    input  wire logic signed [AVG_W-1:0] u2,
    input  wire logic signed [AVG_W-1:0] u3,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output div_lane_t                   lane_a,
    output div_lane_t                   lane_b,
    output side_t                       side
);

    logic [1:0]         vld_reg;
    logic [1:0]         en;
    side_t              sd0_reg;
    logic [WIDTH_W-1:0] h2_reg;
    logic [31:0]        mag1_reg;
    logic [31:0]        mag3_reg;
    div_lane_t          a_reg;
    div_lane_t          b_reg;
    side_t              sd1_reg;

    side_t              sd0_next;
    logic [31:0]        mag1_next;
    logic [31:0]        mag3_next;
    logic signed [32:0] d1;
    logic signed [32:0] d3;
    logic [62:0]        p1;
    logic [62:0]        p2;
    div_lane_t          a_next;
    div_lane_t          b_next;

    assign en[1]     = !vld_reg[1] || !out_stall;
    assign en[0]     = !vld_reg[0] || en[1];
    assign in_stall  = !en[0];
    assign out_valid = vld_reg[1];
    assign lane_a    = a_reg;
    assign lane_b    = b_reg;
    assign side      = sd1_reg;

    always_comb
    begin
        d1 = 33'(u1) - 33'(u2);
        d3 = 33'(u3) - 33'(u2);
        mag1_next = d1[32] ? 32'(-d1) : d1[31:0];
        mag3_next = d3[32] ? 32'(-d3) : d3[31:0];
        sd0_next       = '0;
        sd0_next.h1    = h1;
        sd0_next.h3    = h3;
        sd0_next.s12   = {1'b0, h1} + {1'b0, h2};
        sd0_next.s23   = {1'b0, h2} + {1'b0, h3};
        sd0_next.u2    = u2;
        sd0_next.neg1  = d1[32];
        sd0_next.neg3  = d3[32];
        sd0_next.fault = (sd0_next.s12 == '0) || (sd0_next.s23 == '0);
    end

    // Quotient is known to fit 32 bits, so the top half starts as the remainder
    always_comb
    begin
        p1 = 63'(h2_reg) * 63'(mag1_reg);
        p2 = 63'(h2_reg) * 63'(mag3_reg);
        a_next.rem = {1'b0, p1[62:32]};
        a_next.low = p1[31:0];
        a_next.dvs = sd0_reg.s12;
        a_next.quo = '0;
        b_next.rem = {1'b0, p2[62:32]};
        b_next.low = p2[31:0];
        b_next.dvs = sd0_reg.s23;
        b_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sd0_reg  <= sd0_next;
            h2_reg   <= h2;
            mag1_reg <= mag1_next;
            mag3_reg <= mag3_next;
        end
        if (en[1])
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            sd1_reg <= sd0_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/weno3_div.sv =====
// Two-lane pipelined restoring divider, DIV_STEP quotient bits per stage.
`default_nettype none

module weno3_div
    import weno3_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  div_lane_t      a_in,
    input  div_lane_t      b_in,
    input  side_t          side_in,
    output logic           out_valid,
    input  wire logic      out_stall,
    output div_lane_t      a_out,
    output div_lane_t      b_out,
    output side_t          side_out
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] en;
    div_lane_t             a_reg [DIV_STAGES];
    div_lane_t             b_reg [DIV_STAGES];
    side_t                 sd_reg [DIV_STAGES];

    always_comb
    begin
        en[DIV_STAGES-1] = !vld_reg[DIV_STAGES-1] || !out_stall;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign a_out     = a_reg[DIV_STAGES-1];
    assign b_out     = b_reg[DIV_STAGES-1];
    assign side_out  = sd_reg[DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    vld_reg[k] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    a_reg[k]  <= div_steps(a_in);
                    b_reg[k]  <= div_steps(b_in);
                    sd_reg[k] <= side_in;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    a_reg[k]  <= div_steps(a_reg[k-1]);
                    b_reg[k]  <= div_steps(b_reg[k-1]);
                    sd_reg[k] <= sd_reg[k-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/weno3_weight.sv =====
// Smoothness indicators, pair scaling and the nonlinear weight operands for the second divider.
`default_nettype none

module weno3_weight
    import weno3_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [EPS_W-1:0]  epsilon,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  div_lane_t              a_in,
    input  div_lane_t              b_in,
    input  side_t                  side_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output div_lane_t              a_out,
    output div_lane_t              b_out,
    output side_t                  side_out
);

    localparam int NS = 12;
    localparam int NW = NS - 1;

    typedef struct packed {
        side_t       sd;
        logic [63:0] xa;
        logic [63:0] xb;
        logic [63:0] xc;
        logic [63:0] xd;
        logic [5:0]  k1;
        logic [5:0]  k2;
    } wk_t;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    wk_t           wk_reg  [NW];
    wk_t           wk_next [NW];
    div_lane_t     a_reg;
    div_lane_t     b_reg;
    side_t         sd_reg;
    div_lane_t     a_next;
    div_lane_t     b_next;
    side_t         sd_next;

    logic signed [33:0] e1;
    logic signed [33:0] e2;
    logic signed [33:0] dsum;
    logic [63:0]        bi1;
    logic [63:0]        bi2;
    logic [64:0]        s1;
    logic [64:0]        s2;
    logic [63:0]        sh1;
    logic [63:0]        sh2;
    logic [31:0]        nl;
    logic [31:0]        dl;
    logic [31:0]        nr;
    logic [31:0]        dr;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NS-1];
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign side_out  = sd_reg;

    always_comb
    begin
        // Signed skews and indicator squares
        e1   = side_in.neg1 ? -$signed({2'b00, a_in.quo}) : $signed({2'b00, a_in.quo});
        e2   = side_in.neg3 ? -$signed({2'b00, b_in.quo}) : $signed({2'b00, b_in.quo});
        dsum = e1 + e2;
        wk_next[0]         = '0;
        wk_next[0].sd      = side_in;
        wk_next[0].sd.e1   = e1;
        wk_next[0].sd.e2   = e2;
        wk_next[0].sd.dneg = dsum[33];
        wk_next[0].sd.dmag = dsum[33] ? 33'(-dsum) : dsum[32:0];
        wk_next[0].sd.pbl  = 35'(side_in.u2) - 35'(e2);
        wk_next[0].sd.pbr  = 35'(side_in.u2) + 35'(e2);
        wk_next[0].xa      = 64'(a_in.quo) * 64'(a_in.quo);
        wk_next[0].xb      = 64'(b_in.quo) * 64'(b_in.quo);

        // Indicator 4*e^2 plus epsilon, saturated
        wk_next[1] = wk_reg[0];
        bi1 = (wk_reg[0].xa[63:62] != 2'b00) ? '1 : {wk_reg[0].xa[61:0], 2'b00};
        bi2 = (wk_reg[0].xb[63:62] != 2'b00) ? '1 : {wk_reg[0].xb[61:0], 2'b00};
        s1  = {1'b0, bi1} + 65'(epsilon);
        s2  = {1'b0, bi2} + 65'(epsilon);
        wk_next[1].xa = s1[64] ? '1 : s1[63:0];
        wk_next[1].xb = s2[64] ? '1 : s2[63:0];

        wk_next[2]    = wk_reg[1];
        wk_next[2].k1 = shift_cnt(bit_len64(wk_reg[1].xa | wk_reg[1].xb), 7'd32);

        wk_next[3] = wk_reg[2];
        sh1 = wk_reg[2].xa >> wk_reg[2].k1;
        sh2 = wk_reg[2].xb >> wk_reg[2].k1;
        wk_next[3].xa = (sh1[31:0] == '0) ? 64'd1 : 64'(sh1[31:0]);
        wk_next[3].xb = (sh2[31:0] == '0) ? 64'd1 : 64'(sh2[31:0]);

        wk_next[4]    = wk_reg[3];
        wk_next[4].xa = 64'(wk_reg[3].xa[31:0]) * 64'(wk_reg[3].xa[31:0]);
        wk_next[4].xb = 64'(wk_reg[3].xb[31:0]) * 64'(wk_reg[3].xb[31:0]);

        wk_next[5]    = wk_reg[4];
        wk_next[5].k1 = shift_cnt(bit_len64(wk_reg[4].xa | wk_reg[4].xb), 7'd31);

        wk_next[6] = wk_reg[5];
        sh1 = wk_reg[5].xa >> wk_reg[5].k1;
        sh2 = wk_reg[5].xb >> wk_reg[5].k1;
        wk_next[6].xa = (sh1[30:0] == '0) ? 64'd1 : 64'(sh1[30:0]);
        wk_next[6].xb = (sh2[30:0] == '0) ? 64'd1 : 64'(sh2[30:0]);

        // xa/xb: left numerator and other term; xc/xd: the same for the right face
        wk_next[7]    = wk_reg[6];
        wk_next[7].xa = 64'(wk_reg[6].sd.s23) * 64'(wk_reg[6].xb[30:0]);
        wk_next[7].xb = 64'(wk_reg[6].sd.h1)  * 64'(wk_reg[6].xa[30:0]);
        wk_next[7].xc = 64'(wk_reg[6].sd.h3)  * 64'(wk_reg[6].xb[30:0]);
        wk_next[7].xd = 64'(wk_reg[6].sd.s12) * 64'(wk_reg[6].xa[30:0]);

        wk_next[8]    = wk_reg[7];
        wk_next[8].xb = wk_reg[7].xa + wk_reg[7].xb;
        wk_next[8].xd = wk_reg[7].xc + wk_reg[7].xd;

        wk_next[9]    = wk_reg[8];
        wk_next[9].k1 = shift_cnt(bit_len64(wk_reg[8].xb), 7'd32);
        wk_next[9].k2 = shift_cnt(bit_len64(wk_reg[8].xd), 7'd32);

        wk_next[10]    = wk_reg[9];
        wk_next[10].xa = wk_reg[9].xa >> wk_reg[9].k1;
        wk_next[10].xb = wk_reg[9].xb >> wk_reg[9].k1;
        wk_next[10].xc = wk_reg[9].xc >> wk_reg[9].k2;
        wk_next[10].xd = wk_reg[9].xd >> wk_reg[9].k2;

        // Numerator never exceeds denominator: peel the integer bit, divide the rest
        nl = wk_reg[10].xa[31:0];
        dl = wk_reg[10].xb[31:0];
        nr = wk_reg[10].xc[31:0];
        dr = wk_reg[10].xd[31:0];
        sd_next       = wk_reg[10].sd;
        sd_next.wl_hi = (nl >= dl);
        sd_next.wr_hi = (nr >= dr);
        a_next.rem = sd_next.wl_hi ? nl - dl : nl;
        a_next.low = '0;
        a_next.dvs = dl;
        a_next.quo = '0;
        b_next.rem = sd_next.wr_hi ? nr - dr : nr;
        b_next.low = '0;
        b_next.dvs = dr;
        b_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NW; k++)
        begin
            if (en[k])
            begin
                wk_reg[k] <= wk_next[k];
            end
        end
        if (en[NS-1])
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            sd_reg <= sd_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/weno3_blend.sv =====
// Stencil blend with the nonlinear weights, saturation and fault handling.
`default_nettype none

module weno3_blend
    import weno3_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  div_lane_t                    a_in,
    input  div_lane_t                    b_in,
    input  side_t                        side_in,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [DATA_WIDTH-1:0] face_left,
    output logic signed [DATA_WIDTH-1:0] face_right,
    output logic                         fault
);

    logic [2:0]         vld_reg;
    logic [2:0]         en;

    logic [49:0]        p1l_reg;
    logic [48:0]        p2l_reg;
    logic [49:0]        p1r_reg;
    logic [48:0]        p2r_reg;
    logic signed [34:0] pbl_reg;
    logic signed [34:0] pbr_reg;
    logic               dneg_reg;
    logic               f0_reg;
    logic signed [39:0] vl_reg;
    logic signed [39:0] vr_reg;
    logic               f1_reg;
    logic signed [DATA_WIDTH-1:0] fl_reg;
    logic signed [DATA_WIDTH-1:0] fr_reg;
    logic               f2_reg;

    logic [32:0]        wl;
    logic [32:0]        wr;
    logic [50:0]        tl;
    logic [50:0]        tr;
    logic signed [39:0] rl;
    logic signed [39:0] rr;
    logic signed [39:0] vl_next;
    logic signed [39:0] vr_next;
    logic signed [DATA_WIDTH-1:0] fl_next;
    logic signed [DATA_WIDTH-1:0] fr_next;

    assign en[2]      = !vld_reg[2] || !out_stall;
    assign en[1]      = !vld_reg[1] || en[2];
    assign en[0]      = !vld_reg[0] || en[1];
    assign in_stall   = !en[0];
    assign out_valid  = vld_reg[2];
    assign face_left  = fl_reg;
    assign face_right = fr_reg;
    assign fault      = f2_reg;

    assign wl = {side_in.wl_hi, a_in.quo};
    assign wr = {side_in.wr_hi, b_in.quo};

    always_comb
    begin
        tl = {1'b0, p1l_reg} + 51'(p2l_reg >> FRAC_BITS);
        tr = {1'b0, p1r_reg} + 51'(p2r_reg >> FRAC_BITS);
        rl = $signed(40'(tl >> FRAC_BITS));
        rr = $signed(40'(tr >> FRAC_BITS));
        // Right-face difference is the negated left-face one
        vl_next = dneg_reg  ? 40'(pbl_reg) - rl : 40'(pbl_reg) + rl;
        vr_next = !dneg_reg ? 40'(pbr_reg) - rr : 40'(pbr_reg) + rr;
    end

    always_comb
    begin
        if (vl_reg > SAT_HI)
        begin
            fl_next = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (vl_reg < SAT_LO)
        begin
            fl_next = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            fl_next = vl_reg[DATA_WIDTH-1:0];
        end
        if (vr_reg > SAT_HI)
        begin
            fr_next = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (vr_reg < SAT_LO)
        begin
            fr_next = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            fr_next = vr_reg[DATA_WIDTH-1:0];
        end
        if (f1_reg)
        begin
            fl_next = '0;
            fr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (en[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1l_reg  <= 50'(side_in.dmag) * 50'(wl[32:16]);
            p2l_reg  <= 49'(side_in.dmag) * 49'(wl[15:0]);
            p1r_reg  <= 50'(side_in.dmag) * 50'(wr[32:16]);
            p2r_reg  <= 49'(side_in.dmag) * 49'(wr[15:0]);
            pbl_reg  <= side_in.pbl;
            pbr_reg  <= side_in.pbr;
            dneg_reg <= side_in.dneg;
            f0_reg   <= side_in.fault;
        end
        if (en[1])
        begin
            vl_reg <= vl_next;
            vr_reg <= vr_next;
            f1_reg <= f0_reg;
        end
        if (en[2])
        begin
            fl_reg <= fl_next;
            fr_reg <= fr_next;
            f2_reg <= f1_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/weno3_face_reconstruction.sv =====
// Top level of the third-order WENO face reconstruction pipeline.
`default_nettype none

// Accepts one cell stencil (three widths, three averages) per clock when item_stall is low,
// and returns the left and right face values one transaction per stencil, in order. The
// path has 2 input stages, two 8-stage restoring dividers (4 quotient bits each stage)
// for the width-scaled skews and for the nonlinear weights, 12 stages of indicator,
// scaling and weight arithmetic, and 3 blend and saturation stages. Stages advance
// independently, so empty slots close up behind a stalled output. The user must write
// epsilon via cfg_wr_en/cfg_wr_data only while no transaction is in flight (not enforced).
module weno3_face_reconstruction
    import weno3_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [EPS_W-1:0]         cfg_wr_data,
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic [WIDTH_W-1:0]       width_left,
    input  wire logic [WIDTH_W-1:0]       width_center,
    input  wire logic [WIDTH_W-1:0]       width_right,
    input  wire logic signed [AVG_W-1:0]  avg_left,
    input  wire logic signed [AVG_W-1:0]  avg_center,
    input  wire logic signed [AVG_W-1:0]  avg_right,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic signed [DATA_WIDTH-1:0]  face_left_value,
    output logic signed [DATA_WIDTH-1:0]  face_right_value,
    output logic                          fault
);

    logic [EPS_W-1:0] epsilon_reg;

    logic      fr_valid;
    logic      fr_stall;
    div_lane_t fr_a;
    div_lane_t fr_b;
    side_t     fr_side;
    logic      d1_valid;
    logic      d1_stall;
    div_lane_t d1_a;
    div_lane_t d1_b;
    side_t     d1_side;
    logic      wt_valid;
    logic      wt_stall;
    div_lane_t wt_a;
    div_lane_t wt_b;
    side_t     wt_side;
    logic      d2_valid;
    logic      d2_stall;
    div_lane_t d2_a;
    div_lane_t d2_b;
    side_t     d2_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            epsilon_reg <= cfg_wr_data;
        end
    end

    weno3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_stall  (item_stall),
        .h1        (width_left),
        .h2        (width_center),
        .h3        (width_right),
        .u1        (avg_left),
        .u2        (avg_center),
        .u3        (avg_right),
        .out_valid (fr_valid),
        .out_stall (fr_stall),
        .lane_a    (fr_a),
        .lane_b    (fr_b),
        .side      (fr_side)
    );

    weno3_div u_skew_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .a_in      (fr_a),
        .b_in      (fr_b),
        .side_in   (fr_side),
        .out_valid (d1_valid),
        .out_stall (d1_stall),
        .a_out     (d1_a),
        .b_out     (d1_b),
        .side_out  (d1_side)
    );

    weno3_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .epsilon   (epsilon_reg),
        .in_valid  (d1_valid),
        .in_stall  (d1_stall),
        .a_in      (d1_a),
        .b_in      (d1_b),
        .side_in   (d1_side),
        .out_valid (wt_valid),
        .out_stall (wt_stall),
        .a_out     (wt_a),
        .b_out     (wt_b),
        .side_out  (wt_side)
    );

    weno3_div u_weight_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wt_valid),
        .in_stall  (wt_stall),
        .a_in      (wt_a),
        .b_in      (wt_b),
        .side_in   (wt_side),
        .out_valid (d2_valid),
        .out_stall (d2_stall),
        .a_out     (d2_a),
        .b_out     (d2_b),
        .side_out  (d2_side)
    );

    weno3_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d2_valid),
        .in_stall   (d2_stall),
        .a_in       (d2_a),
        .b_in       (d2_b),
        .side_in    (d2_side),
        .out_valid  (result_valid),
        .out_stall  (result_stall),
        .face_left  (face_left_value),
        .face_right (face_right_value),
        .fault      (fault)
    );

endmodule

`default_nettype wire

// ===== tb/sv/weno3_face_checker.sv =====
// Checker for the WENO3 face reconstruction block: predicts each result and compares it.
module weno3_face_checker
    import weno3_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [EPS_W-1:0]         cfg_wr_data,
    input  wire logic                     item_valid,
    input  wire logic                     item_stall,
    input  wire logic [WIDTH_W-1:0]       width_left,
    input  wire logic [WIDTH_W-1:0]       width_center,
    input  wire logic [WIDTH_W-1:0]       width_right,
    input  wire logic signed [AVG_W-1:0]  avg_left,
    input  wire logic signed [AVG_W-1:0]  avg_center,
    input  wire logic signed [AVG_W-1:0]  avg_right,
    input  wire logic                     result_valid,
    input  wire logic                     result_stall,
    input  wire logic signed [DATA_WIDTH-1:0] face_left_value,
    input  wire logic signed [DATA_WIDTH-1:0] face_right_value,
    input  wire logic                     fault,
    output int                            mismatches,
    output int                            pending,
    output int                            checked,
    output int                            faults_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] left_face;
        logic signed [DATA_WIDTH-1:0] right_face;
        logic                         flag;
    } faces_t;

    faces_t      face_queue[$];
    bit [63:0]   eps_reg;

    function automatic bit [63:0] mag64(input longint d);
        return d < 0 ? 64'(-d) : 64'(d);
    endfunction

    // trunc(h * d / sum) toward zero
    function automatic longint width_skew(input bit [63:0] h, input bit [63:0] sum,
                                          input longint d);
        bit [63:0] q;
        if (sum == 0)
        begin
            return 0;
        end
        q = (h * mag64(d)) / sum;
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit [63:0] smooth_sum(input longint e, input bit [63:0] eps);
        bit [63:0] m;
        bit [63:0] sq;
        bit [63:0] b;
        bit [63:0] s;
        m  = mag64(e);
        sq = m * m;
        b  = ((sq >> 62) != 0) ? '1 : (sq << 2);
        s  = b + eps;
        return (s < b) ? '1 : s;
    endfunction

    function automatic void rescale(inout bit [63:0] a, inout bit [63:0] b, input int bits);
        bit [63:0] m;
        int        k;
        m = a | b;
        k = 0;
        while (k < 63 && ((m >> k) >> bits) != 0)
        begin
            k++;
        end
        a = a >> k;
        b = b >> k;
        if (a == 0)
        begin
            a = 1;
        end
        if (b == 0)
        begin
            b = 1;
        end
    endfunction

    function automatic bit [63:0] face_weight(input bit [63:0] ca, input bit [63:0] qa,
                                              input bit [63:0] cb, input bit [63:0] qb);
        bit [63:0] num;
        bit [63:0] den;
        int        k;
        num = ca * qa;
        den = num + cb * qb;
        k = 0;
        while (k < 63 && ((den >> k) >> 32) != 0)
        begin
            k++;
        end
        num = num >> k;
        den = den >> k;
        if (den == 0)
        begin
            return 0;
        end
        return (num << 32) / den;
    endfunction

    function automatic longint blend_sat(input longint pa, input longint pb, input bit [63:0] w);
        longint    d;
        bit [63:0] m;
        bit [63:0] t;
        longint    r;
        longint    v;
        d = pa - pb;
        m = mag64(d);
        t = m * (w >> 16) + ((m * (w & 64'hFFFF)) >> 16);
        r = longint'(t >> 16);
        v = d < 0 ? pb - r : pb + r;
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic faces_t reconstruct_faces(input bit [63:0] h1, input bit [63:0] h2,
                                                 input bit [63:0] h3, input longint u1,
                                                 input longint u2, input longint u3,
                                                 input bit [63:0] eps);
        faces_t    f;
        bit [63:0] s12;
        bit [63:0] s23;
        longint    e1;
        longint    e2;
        bit [63:0] s1;
        bit [63:0] s2;
        bit [63:0] q1;
        bit [63:0] q2;
        bit [63:0] wl;
        bit [63:0] wr;
        longint    fl;
        longint    fr;
        s12 = h1 + h2;
        s23 = h2 + h3;
        if (s12 == 0 || s23 == 0)
        begin
            f.left_face  = '0;
            f.right_face = '0;
            f.flag       = 1'b1;
            return f;
        end
        e1 = width_skew(h2, s12, u1 - u2);
        e2 = width_skew(h2, s23, u3 - u2);
        s1 = smooth_sum(e1, eps);
        s2 = smooth_sum(e2, eps);
        rescale(s1, s2, 32);
        q1 = s1 * s1;
        q2 = s2 * s2;
        rescale(q1, q2, 31);
        wl = face_weight(s23, q2, h1, q1);
        wr = face_weight(h3, q2, s12, q1);
        fl = blend_sat(u2 + e1, u2 - e2, wl);
        fr = blend_sat(u2 - e1, u2 + e2, wr);
        f.left_face  = fl[31:0];
        f.right_face = fr[31:0];
        f.flag       = 1'b0;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        faces_t exp_f;
        if (!rst_n)
        begin
            eps_reg     <= 64'(EPS_RESET);
            mismatches  <= 0;
            pending     <= 0;
            checked     <= 0;
            faults_seen <= 0;
            face_queue.delete();
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                face_queue.push_back(reconstruct_faces(64'(width_left), 64'(width_center),
                    64'(width_right), longint'(avg_left), longint'(avg_center),
                    longint'(avg_right), eps_reg));
            end
            if (cfg_wr_en)
            begin
                eps_reg <= 64'(cfg_wr_data);
            end
            if (result_valid && !result_stall)
            begin
                checked <= checked + 1;
                if (fault)
                begin
                    faults_seen <= faults_seen + 1;
                end
                if (face_queue.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("ERROR: extra result left=%0d right=%0d fault=%0b",
                                 face_left_value, face_right_value, fault);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_f = face_queue.pop_front();
                    if (exp_f.left_face !== face_left_value
                        || exp_f.right_face !== face_right_value
                        || exp_f.flag !== fault)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("ERROR: result %0d exp %0d %0d %0b got %0d %0d %0b",
                                     checked, exp_f.left_face, exp_f.right_face, exp_f.flag,
                                     face_left_value, face_right_value, fault);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= face_queue.size();
        end
    end

endmodule

// ===== tb/sv/weno3_face_reconstruction_test.sv =====
// Top of the WENO3 face reconstruction testbench: clock, reset, stimulus and verdict.
module weno3_face_reconstruction_test;
    timeunit 1ns;
    timeprecision 1ps;
    import weno3_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [EPS_W-1:0]              cfg_wr_data = '0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic [WIDTH_W-1:0]            width_left = '0;
    logic [WIDTH_W-1:0]            width_center = '0;
    logic [WIDTH_W-1:0]            width_right = '0;
    logic signed [AVG_W-1:0]       avg_left = '0;
    logic signed [AVG_W-1:0]       avg_center = '0;
    logic signed [AVG_W-1:0]       avg_right = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0]  face_left_value;
    logic signed [DATA_WIDTH-1:0]  face_right_value;
    logic                          fault;

    int mismatches;
    int pending;
    int checked;
    int faults_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    weno3_face_reconstruction i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .width_left(width_left), .width_center(width_center), .width_right(width_right),
        .avg_left(avg_left), .avg_center(avg_center), .avg_right(avg_right),
        .result_valid(result_valid), .result_stall(result_stall),
        .face_left_value(face_left_value), .face_right_value(face_right_value), .fault(fault)
    );

    weno3_face_checker i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .width_left(width_left), .width_center(width_center), .width_right(width_right),
        .avg_left(avg_left), .avg_center(avg_center), .avg_right(avg_right),
        .result_valid(result_valid), .result_stall(result_stall),
        .face_left_value(face_left_value), .face_right_value(face_right_value), .fault(fault),
        .mismatches(mismatches), .pending(pending), .checked(checked),
        .faults_seen(faults_seen)
    );

    always @(posedge clk)
    begin
        result_stall <= ($urandom % 100) < recv_idle_pct;
    end

    // End the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_stencil(input logic [WIDTH_W-1:0] h1, input logic [WIDTH_W-1:0] h2,
                                input logic [WIDTH_W-1:0] h3, input logic [31:0] u1,
                                input logic [31:0] u2, input logic [31:0] u3);
        if (($urandom % 100) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while (($urandom % 100) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        width_left   <= h1;
        width_center <= h2;
        width_right  <= h3;
        avg_left     <= u1;
        avg_center   <= u2;
        avg_right    <= u3;
        item_valid   <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    // Drop valid and hold until the pipeline has drained.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [WIDTH_W-1:0] rand_width();
        case ($urandom % 8)
            0:       return '0;
            1:       return WIDTH_W'($urandom);
            2:       return WIDTH_W'($urandom_range(1, 16));
            default: return WIDTH_W'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    function automatic logic [31:0] rand_avg(input logic [31:0] near);
        case ($urandom % 4)
            0:       return $urandom;
            1:       return near;
            default: return near + 32'($signed($urandom_range(0, 32'h0008_0000))
                                       - 32'sh0004_0000);
        endcase
    endfunction

    task automatic random_stencils(input int count);
        logic [31:0] mid;
        for (int i = 0; i < count; i++)
        begin
            mid = $urandom;
            send_stencil(rand_width(), rand_width(), rand_width(),
                         rand_avg(mid), mid, rand_avg(mid));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero width sums, extreme widths and averages, flat data.
        send_stencil('0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_stencil('0, '0, 31'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_stencil(31'h0001_0000, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
        send_stencil('0, 31'h0001_0000, 31'h0001_0000, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
        send_stencil('1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_stencil('1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_stencil(31'h1, '1, 31'h1, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        send_stencil('1, 31'h1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_stencil(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h5, 32'h5, 32'h5);
        send_stencil(31'h0001_0000, 31'h0002_0000, 31'h0000_8000,
                     32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
        send_stencil(31'h0001_0000, 31'h0001_0000, '0, 32'hFFFF_0000, 32'h0, 32'h0001_0000);
        send_stencil('0, 31'h1, '0, 32'h0, 32'h0, 32'h0);
        send_stencil('1, '0, '1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);

        write_epsilon('0);
        send_stencil(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h7, 32'h7, 32'h7);
        send_stencil(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        write_epsilon('1);
        send_stencil(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'h7FFF_FFFF, 32'h0,
                     32'h8000_0000);
        send_stencil(31'h0003_0000, 31'h0001_0000, 31'h0002_0000, 32'h1, 32'h0001_0000, 32'h3);

        // Random phases, with idling on both sides at swapped ratios, then with no idling.
        write_epsilon(32'd1);
        send_idle_pct = 33;
        recv_idle_pct = 48;
        random_stencils(300);
        drain();
        random_stencils(300);
        write_epsilon($urandom);
        send_idle_pct = 48;
        recv_idle_pct = 33;
        random_stencils(300);
        write_epsilon('1);
        random_stencils(300);
        write_epsilon('0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_stencils(300);
        write_epsilon(EPS_RESET);
        random_stencils(300);

        drain();
        $display("Sent %0d stencils across several epsilon values and stall patterns.", sent);
        $display("%0d results checked, %0d with a zero width sum.", checked, faults_seen);
        if (mismatches == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
